[rtl/core/kct_pkg.sv]
// Package for the keyed count table: table sizing, record layout,
// command and status codes. No dependencies.
package kct_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int POSTAL_W = 40;
  localparam int NAME_W   = 64;
  localparam int TIME_W   = 32;
  localparam int REQ_W    = 4;
  localparam int ITV_W    = 8;
  localparam int DOSE_W   = 20;
  localparam int TOTAL_W  = 32;
  localparam int USED_W   = 7;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [POSTAL_W-1:0] postal;
    logic [NAME_W-1:0]   name;
    logic [TIME_W-1:0]   stamp;
    logic [REQ_W-1:0]    required;
    logic [ITV_W-1:0]    interval;
    logic [TOTAL_W-1:0]  total;
  } rec_t;

endpackage

[rtl/core/keyed_count_table.sv]
// Keyed count table: record memory, in-order key scan and shift-down compaction.
// Depends on kct_pkg.
// Flow: the request is registered, records are read in order until a key match or the last
// used record, then S_UPD updates; a delete with later records shifts them down first.
// Throughput: one request at a time; busy stays high until the result strobe.
// The scan and the compaction share one memory read port and one write port,
// one record per cycle. Reset empties the table; record contents are not cleared.
// out_valid is a one-cycle strobe; the receiver cannot stall.
module keyed_count_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_cmd,
  input  logic [kct_pkg::POSTAL_W-1:0]  in_postal_code,
  input  logic [kct_pkg::NAME_W-1:0]    in_vaccine_name,
  input  logic [kct_pkg::TIME_W-1:0]    in_timestamp,
  input  logic [kct_pkg::REQ_W-1:0]     in_required_doses,
  input  logic [kct_pkg::ITV_W-1:0]     in_interval_days,
  input  logic [kct_pkg::DOSE_W-1:0]    in_dose_count,
  output logic                          out_valid,
  output logic                          out_found,
  output logic                          out_removed,
  output logic [1:0]                    out_status,
  output logic [kct_pkg::USED_W-1:0]    out_entries_used,
  output logic [kct_pkg::TOTAL_W-1:0]   out_resulting_count
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;

  kct_pkg::rec_t mem [kct_pkg::ENTRIES];
  kct_pkg::rec_t rd_data_r;

  logic [2:0]                  state_r, state_nxt;
  logic [kct_pkg::CNT_W-1:0]   used_r, used_nxt;
  logic [kct_pkg::CNT_W-1:0]   ptr_r, ptr_nxt;
  logic                        rd_vld_r, rd_vld_nxt;
  logic [kct_pkg::IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic                        hit_r, hit_nxt;
  logic [kct_pkg::IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  kct_pkg::rec_t               hit_rec_r, hit_rec_nxt;
  logic                        out_valid_r, out_valid_nxt;

  logic                        req_cmd_r;
  kct_pkg::rec_t               req_rec_r;
  logic [kct_pkg::DOSE_W-1:0]  req_dose_r;

  logic                        res_found_r, res_found_nxt;
  logic                        res_removed_r, res_removed_nxt;
  logic [1:0]                  res_status_r, res_status_nxt;
  logic [kct_pkg::TOTAL_W-1:0] res_count_r, res_count_nxt;

  logic                        mem_we;
  logic [kct_pkg::IDX_W-1:0]   mem_wa;
  kct_pkg::rec_t               mem_wd;
  logic [kct_pkg::IDX_W-1:0]   mem_ra;

  logic                        key_eq;
  logic                        last_rd;
  logic [kct_pkg::TOTAL_W:0]   sum;
  logic [kct_pkg::TOTAL_W-1:0] dose_ext;
  logic                        accept;

  assign accept   = start && (state_r == S_IDLE);
  assign key_eq   = (rd_data_r.postal == req_rec_r.postal) &&
                    (rd_data_r.name == req_rec_r.name) &&
                    (rd_data_r.stamp == req_rec_r.stamp);
  assign last_rd  = ({1'b0, rd_idx_r} + kct_pkg::CNT_W'(1)) == used_r;
  assign dose_ext = kct_pkg::TOTAL_W'(req_dose_r);
  assign sum      = {1'b0, hit_rec_r.total} + {1'b0, dose_ext};

  always_comb begin
    state_nxt       = state_r;
    used_nxt        = used_r;
    ptr_nxt         = ptr_r;
    rd_vld_nxt      = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    hit_rec_nxt     = hit_rec_r;
    out_valid_nxt   = 1'b0;
    res_found_nxt   = res_found_r;
    res_removed_nxt = res_removed_r;
    res_status_nxt  = res_status_r;
    res_count_nxt   = res_count_r;
    mem_we          = 1'b0;
    mem_wa          = hit_idx_r;
    mem_wd          = hit_rec_r;
    mem_ra          = ptr_r[kct_pkg::IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          ptr_nxt = '0;
          hit_nxt = 1'b0;
          state_nxt = (used_r == '0) ? S_UPD : S_SCAN;
        end
      end

      S_SCAN: begin
        if (ptr_r < used_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = ptr_r[kct_pkg::IDX_W-1:0];
          ptr_nxt    = ptr_r + kct_pkg::CNT_W'(1);
        end
        if (rd_vld_r) begin
          if (key_eq) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = rd_idx_r;
            hit_rec_nxt = rd_data_r;
            rd_vld_nxt  = 1'b0;
            state_nxt   = S_UPD;
          end else if (last_rd) begin
            rd_vld_nxt = 1'b0;
            state_nxt  = S_UPD;
          end
        end
      end

      S_UPD: begin
        res_found_nxt   = hit_r;
        res_removed_nxt = 1'b0;
        res_status_nxt  = kct_pkg::ST_OK;
        res_count_nxt   = '0;
        state_nxt       = S_IDLE;
        out_valid_nxt   = 1'b1;
        if (req_cmd_r == kct_pkg::CMD_ADD) begin
          if (hit_r) begin
            mem_we       = 1'b1;
            mem_wa       = hit_idx_r;
            mem_wd       = hit_rec_r;
            mem_wd.total = sum[kct_pkg::TOTAL_W] ? '1 : sum[kct_pkg::TOTAL_W-1:0];
            res_count_nxt = mem_wd.total;
          end else if (used_r < kct_pkg::CNT_W'(kct_pkg::ENTRIES)) begin
            mem_we        = 1'b1;
            mem_wa        = used_r[kct_pkg::IDX_W-1:0];
            mem_wd        = req_rec_r;
            used_nxt      = used_r + kct_pkg::CNT_W'(1);
            res_count_nxt = dose_ext;
          end else begin
            res_status_nxt = kct_pkg::ST_FULL;
          end
        end else begin
          if (!hit_r) begin
            res_status_nxt = kct_pkg::ST_NOT_FOUND;
          end else if (hit_rec_r.total <= dose_ext) begin
            res_removed_nxt = 1'b1;
            if (({1'b0, hit_idx_r} + kct_pkg::CNT_W'(1)) == used_r) begin
              used_nxt = used_r - kct_pkg::CNT_W'(1);
            end else begin
              ptr_nxt       = {1'b0, hit_idx_r} + kct_pkg::CNT_W'(1);
              out_valid_nxt = 1'b0;
              state_nxt     = S_SHIFT;
            end
          end else begin
            mem_we        = 1'b1;
            mem_wa        = hit_idx_r;
            mem_wd        = hit_rec_r;
            mem_wd.total  = hit_rec_r.total - dose_ext;
            res_count_nxt = mem_wd.total;
          end
        end
      end

      S_SHIFT: begin
        if (ptr_r < used_r) begin
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = ptr_r[kct_pkg::IDX_W-1:0];
          ptr_nxt    = ptr_r + kct_pkg::CNT_W'(1);
        end
        if (rd_vld_r) begin
          mem_we = 1'b1;
          mem_wa = rd_idx_r - kct_pkg::IDX_W'(1);
          mem_wd = rd_data_r;
          if (last_rd) begin
            rd_vld_nxt    = 1'b0;
            used_nxt      = used_r - kct_pkg::CNT_W'(1);
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r         <= ptr_nxt;
    rd_idx_r      <= rd_idx_nxt;
    hit_r         <= hit_nxt;
    hit_idx_r     <= hit_idx_nxt;
    hit_rec_r     <= hit_rec_nxt;
    res_found_r   <= res_found_nxt;
    res_removed_r <= res_removed_nxt;
    res_status_r  <= res_status_nxt;
    res_count_r   <= res_count_nxt;
    if (accept) begin
      req_cmd_r          <= in_cmd;
      req_rec_r.postal   <= in_postal_code;
      req_rec_r.name     <= in_vaccine_name;
      req_rec_r.stamp    <= in_timestamp;
      req_rec_r.required <= in_required_doses;
      req_rec_r.interval <= in_interval_days;
      req_rec_r.total    <= kct_pkg::TOTAL_W'(in_dose_count);
      req_dose_r         <= in_dose_count;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  assign busy                = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_found           = res_found_r;
  assign out_removed         = res_removed_r;
  assign out_status          = res_status_r;
  assign out_entries_used    = kct_pkg::USED_W'(used_r);
  assign out_resulting_count = res_count_r;

endmodule
